>>> sv/keyword_token_lexer_top_macros.svh
// assertion macros shared by the keyword token lexer modules
// expects signals clk and arst_n in the including module
`ifndef KEYWORD_TOKEN_LEXER_TOP_MACROS_SVH
`define KEYWORD_TOKEN_LEXER_TOP_MACROS_SVH

// condition implies consequence in the same cycle
`define KWL_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// condition must never hold
`define KWL_ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

`endif

>>> sv/kwl_pkg.sv
// shared types and constants of the keyword token lexer
// no dependencies
package kwl_pkg;

	// longest buffered identifier prefix
	localparam int KEYWORD_MAX = 6;
	localparam int WLEN_W = $clog2(KEYWORD_MAX + 2);
	localparam int WIDX_W = $clog2(KEYWORD_MAX);
	localparam logic [15:0] POS_MAX = 16'hFFFF;

	// result queue
	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

	typedef enum logic [1:0] {
		MODE_GAP  = 2'd0,
		MODE_NUM  = 2'd1,
		MODE_WORD = 2'd2
	} scan_mode_t;

	typedef enum logic [4:0] {
		KIND_EOF    = 5'd0,
		KIND_PLUS   = 5'd1,
		KIND_MINUS  = 5'd2,
		KIND_STAR   = 5'd3,
		KIND_SLASH  = 5'd4,
		KIND_EQUAL  = 5'd5,
		KIND_SEMI   = 5'd6,
		KIND_LPAREN = 5'd7,
		KIND_RPAREN = 5'd8,
		KIND_LBRACE = 5'd9,
		KIND_RBRACE = 5'd10,
		KIND_INT    = 5'd11,
		KIND_LET    = 5'd12,
		KIND_VAR    = 5'd13,
		KIND_IF     = 5'd14,
		KIND_WHILE  = 5'd15,
		KIND_RETURN = 5'd16,
		KIND_IDENT  = 5'd17
	} token_kind_t;

	typedef struct packed {
		token_kind_t kind;
		logic        bad_char;
		logic [15:0] error_line;
		logic [15:0] error_col;
		logic        last_of_run;
	} result_t;

	// results caused by one accepted byte, slot 0 first
	typedef struct packed {
		logic [1:0]        count;
		result_t [1:0]     slot;
	} scan_out_t;

endpackage

>>> sv/kwl_scan.sv
// scanner state and per-byte token decision
// depends on kwl_pkg and keyword_token_lexer_top_macros.svh
`include "keyword_token_lexer_top_macros.svh"

module kwl_scan (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [7:0]        ch,
	output kwl_pkg::scan_out_t res
);
	import kwl_pkg::*;

	localparam logic [WLEN_W-1:0] WLEN_MAX = WLEN_W'(KEYWORD_MAX);
	localparam logic [WLEN_W-1:0] WLEN_ONE = WLEN_W'(1);

	scan_mode_t                  mode_q, mode_d;
	logic [WLEN_W-1:0]           wlen_q, wlen_d;
	logic [KEYWORD_MAX-1:0][7:0] wbytes_q, wbytes_d;
	logic [15:0]                 line_q, line_d, col_q, col_d;

	logic        is_num, is_letter, is_space, cont, advance, pend, own;
	token_kind_t pend_kind, op;
	result_t     pend_res, own_res;

	// operator byte to kind, eof when not an operator
	function automatic token_kind_t op_kind(input logic [7:0] c);
		unique case (c)
			"+": op_kind = KIND_PLUS;
			"-": op_kind = KIND_MINUS;
			"*": op_kind = KIND_STAR;
			"/": op_kind = KIND_SLASH;
			"=": op_kind = KIND_EQUAL;
			";": op_kind = KIND_SEMI;
			"(": op_kind = KIND_LPAREN;
			")": op_kind = KIND_RPAREN;
			"{": op_kind = KIND_LBRACE;
			"}": op_kind = KIND_RBRACE;
			default: op_kind = KIND_EOF;
		endcase
	endfunction

	// keyword match over the buffered bytes, all compares in parallel
	function automatic token_kind_t word_kind(input logic [WLEN_W-1:0] len,
			input logic [KEYWORD_MAX-1:0][7:0] b);
		priority if (len == WLEN_W'(3) && b[0] == "l" && b[1] == "e" && b[2] == "t")
			word_kind = KIND_LET;
		else if (len == WLEN_W'(3) && b[0] == "v" && b[1] == "a" && b[2] == "r")
			word_kind = KIND_VAR;
		else if (len == WLEN_W'(2) && b[0] == "i" && b[1] == "f")
			word_kind = KIND_IF;
		else if (len == WLEN_W'(5) && b[0] == "w" && b[1] == "h" && b[2] == "i"
				&& b[3] == "l" && b[4] == "e")
			word_kind = KIND_WHILE;
		else if (len == WLEN_W'(6) && b[0] == "r" && b[1] == "e" && b[2] == "t"
				&& b[3] == "u" && b[4] == "r" && b[5] == "n")
			word_kind = KIND_RETURN;
		else
			word_kind = KIND_IDENT;
	endfunction

	// byte classes
	assign is_num    = (ch >= "0") && (ch <= "9");
	assign is_letter = ((ch >= "a") && (ch <= "z")) || ((ch >= "A") && (ch <= "Z"))
		|| (ch == "_");
	assign is_space  = (ch == " ") || ((ch >= 8'd9) && (ch <= 8'd13));
	assign op        = op_kind(ch);

	// next state and results for the byte on the input
	always_comb begin
		mode_d    = mode_q;
		wlen_d    = wlen_q;
		wbytes_d  = wbytes_q;
		line_d    = line_q;
		col_d     = col_q;
		cont      = 1'b0;
		advance   = 1'b0;
		pend      = 1'b0;
		pend_kind = KIND_INT;
		own       = 1'b0;
		own_res   = '0;
		own_res.kind = KIND_EOF;

		// pending number or identifier: extend or close
		unique case (mode_q)
			MODE_NUM: begin
				if (is_num) cont = 1'b1;
				else pend = 1'b1;
			end
			MODE_WORD: begin
				if (is_num || is_letter) begin
					cont = 1'b1;
					if (wlen_q < WLEN_MAX) wbytes_d[wlen_q[WIDX_W-1:0]] = ch;
					if (wlen_q <= WLEN_MAX) wlen_d = wlen_q + WLEN_ONE;
				end else begin
					pend      = 1'b1;
					pend_kind = word_kind(wlen_q, wbytes_q);
				end
			end
			default: ;
		endcase

		if (cont) begin
			advance = 1'b1;
		end else begin
			mode_d = MODE_GAP;
			if (ch == 8'd0) begin
				// end of text: eof and position back to the start
				own    = 1'b1;
				line_d = 16'd1;
				col_d  = 16'd1;
			end else begin
				advance = 1'b1;
				priority if (op != KIND_EOF) begin
					own          = 1'b1;
					own_res.kind = op;
				end else if (is_num) begin
					mode_d = MODE_NUM;
				end else if (is_letter) begin
					mode_d      = MODE_WORD;
					wbytes_d[0] = ch;
					wlen_d      = WLEN_ONE;
				end else if (!is_space) begin
					own                = 1'b1;
					own_res.bad_char   = 1'b1;
					own_res.error_line = line_q;
					own_res.error_col  = col_q;
				end
			end
		end

		// position of the next byte, saturating
		if (advance) begin
			if (ch == 8'h0A) begin
				if (line_q != POS_MAX) line_d = line_q + 16'd1;
				col_d = 16'd1;
			end else if (col_q != POS_MAX) begin
				col_d = col_q + 16'd1;
			end
		end

		pend_res      = '0;
		pend_res.kind = pend_kind;

		// pack results in order, mark the final one
		res.count                = {1'b0, pend} + {1'b0, own};
		res.slot[0]              = pend ? pend_res : own_res;
		res.slot[0].last_of_run  = !(pend && own);
		res.slot[1]              = own_res;
		res.slot[1].last_of_run  = 1'b1;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_GAP;
			wlen_q <= '0;
			line_q <= 16'd1;
			col_q  <= 16'd1;
		end else if (accept) begin
			mode_q <= mode_d;
			wlen_q <= wlen_d;
			line_q <= line_d;
			col_q  <= col_d;
		end
	end

	// identifier byte buffer, no reset
	always_ff @(posedge clk) begin
		if (accept) wbytes_q <= wbytes_d;
	end

	`KWL_ASSERT_IMPL(a_eof_resets_pos, $past(arst_n) && $past(accept) && $past(ch) == 8'd0,
		line_q == 16'd1 && col_q == 16'd1 && mode_q == MODE_GAP,
		"position not reset after end of text")
	`KWL_ASSERT_IMPL(a_two_needs_pending, res.count == 2'd2,
		mode_q != MODE_GAP && res.slot[0].bad_char == 1'b0,
		"second result without a pending token")
	`KWL_ASSERT_NEVER(a_count_range, res.count == 2'd3, "more than two results per byte")
	`KWL_ASSERT_NEVER(a_wlen_range, wlen_q > WLEN_MAX + WLEN_ONE,
		"identifier length past saturation")

endmodule

>>> sv/kwl_out_fifo.sv
// result queue: takes up to two results per cycle, hands out one
// depends on kwl_pkg and keyword_token_lexer_top_macros.svh
`include "keyword_token_lexer_top_macros.svh"

module kwl_out_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  kwl_pkg::scan_out_t wr,
	output logic               room,
	output logic               rd_valid,
	input  logic               rd_ready,
	output kwl_pkg::result_t   rd_data
);
	import kwl_pkg::*;

	result_t [FIFO_DEPTH-1:0] mem_q;
	logic [PTR_W-1:0]         wr_ptr_q, rd_ptr_q, wr_ptr_nx;
	logic [CNT_W-1:0]         count_q, push_n;
	logic                     pop;

	assign push_n    = push ? CNT_W'(wr.count) : '0;
	assign pop       = rd_valid && rd_ready;
	assign wr_ptr_nx = wr_ptr_q + PTR_W'(1);
	assign room      = count_q <= CNT_W'(FIFO_DEPTH - 2);
	assign rd_valid  = count_q != '0;
	assign rd_data   = mem_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(push_n);
			if (pop) rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			count_q  <= count_q + push_n - CNT_W'(pop);
		end
	end

	// storage words
	always_ff @(posedge clk) begin
		if (push_n != '0) mem_q[wr_ptr_q] <= wr.slot[0];
		if (push_n == CNT_W'(2)) mem_q[wr_ptr_nx] <= wr.slot[1];
	end

	`KWL_ASSERT_NEVER(a_overfill, count_q > CNT_W'(FIFO_DEPTH), "result queue overfilled")
	`KWL_ASSERT_IMPL(a_push_room, push, room, "byte taken without room for two results")
	`KWL_ASSERT_IMPL(a_count_track, $past(arst_n),
		count_q == $past(count_q) + $past(push_n) - CNT_W'($past(pop)),
		"fill count out of step with pushes and pops")

endmodule

>>> sv/keyword_token_lexer_top.sv
// Keyword token lexer, top level.
// Source bytes enter on the s_ stream, one byte per word; byte 0 ends a text.
// Tokens leave on the m_ stream, one result per word. m_tlast marks the
// final result caused by one input byte; whitespace and bytes that extend a
// number or identifier cause no result, a byte that closes one causes one,
// or two if it is itself an operator, end of text or bad byte. Throughput:
// one byte per cycle while each byte causes at most one result and m_tready
// is high; a byte causing two results adds a word absorbed by the four-word
// result queue. s_tready is high while the queue has room for two words, so
// a stalled receiver backs up into s_tready after the queue fills.
// Reset clears the scan mode and identifier length, sets line and column to
// one and empties the result queue. Keyword compare runs in parallel over
// the six buffered identifier bytes in the same cycle the byte is taken.
// depends on kwl_pkg, kwl_scan, kwl_out_fifo
module keyword_token_lexer_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // ch[7:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // token_kind[4:0], error_line[20:5], error_col[36:21]
	output logic        m_tuser,   // bad_char
	output logic        m_tlast    // last_of_run
);
	import kwl_pkg::*;

	logic      accept;
	scan_out_t scan_res;
	result_t   head;

	assign accept = s_tvalid && s_tready;

	// per-byte scanner
	kwl_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.ch     (s_tdata),
		.res    (scan_res)
	);

	// result queue
	kwl_out_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (accept),
		.wr       (scan_res),
		.room     (s_tready),
		.rd_valid (m_tvalid),
		.rd_ready (m_tready),
		.rd_data  (head)
	);

	// output word packing
	assign m_tdata = {3'b000, head.error_col, head.error_line, head.kind};
	assign m_tuser = head.bad_char;
	assign m_tlast = head.last_of_run;

endmodule

>>> test/keyword_token_lexer_top_tb.sv
// testbench for the keyword token lexer: drives byte streams, predicts tokens in step
// with each accepted byte and checks every token word leaving the block
// depends on kwl_pkg and keyword_token_lexer_top
`timescale 1ns / 100ps

module keyword_token_lexer_top_tb;
	import kwl_pkg::*;

	localparam int LIMIT      = 20000;
	localparam int HOLD_AT    = 350;
	localparam int HOLD_LEN   = 200;
	localparam int QUIET_FROM = 700;
	localparam int QUIET_TO   = 1000;
	localparam int RAND_ITEMS = 750;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'd0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic        m_tuser;
	logic        m_tlast;

	keyword_token_lexer_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	// 12 ns clock
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// source bytes waiting to go out and tokens still due from the block
	logic [7:0] src_bytes[$];
	result_t    tokens_due[$];
	int         rand_items;
	int         cyc;
	int         hold_left;
	logic       quiet;
	logic       failed = 1'b0;

	// lexer state as the predictor sees it
	scan_mode_t scan = MODE_GAP;
	logic [7:0] word_buf [KEYWORD_MAX];
	int         word_len = 0;
	logic [15:0] line_no = 16'd1;
	logic [15:0] col_no = 16'd1;

	string      keywords[5] = '{"let", "var", "if", "while", "return"};
	string      op_chars = "+-*/=;(){}";
	string      odd_chars = "!#$%&',.:<>?@[]^|~";
	logic [7:0] ws_set[6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};

	function automatic logic is_num(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_letter(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
	endfunction

	function automatic logic is_space(logic [7:0] c);
		return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
	endfunction

	function automatic token_kind_t op_kind(logic [7:0] c);
		case (c)
			"+": return KIND_PLUS;
			"-": return KIND_MINUS;
			"*": return KIND_STAR;
			"/": return KIND_SLASH;
			"=": return KIND_EQUAL;
			";": return KIND_SEMI;
			"(": return KIND_LPAREN;
			")": return KIND_RPAREN;
			"{": return KIND_LBRACE;
			"}": return KIND_RBRACE;
			default: return KIND_EOF;
		endcase
	endfunction

	function automatic result_t make_token(token_kind_t k, logic bad, logic [15:0] ln,
			logic [15:0] col);
		result_t r;
		r.kind = k;
		r.bad_char = bad;
		r.error_line = ln;
		r.error_col = col;
		r.last_of_run = 1'b0;
		return r;
	endfunction

	// keyword match over the buffered identifier prefix
	function automatic token_kind_t word_kind();
		if (word_len == 3 && {word_buf[0], word_buf[1], word_buf[2]} == "let")
			return KIND_LET;
		if (word_len == 3 && {word_buf[0], word_buf[1], word_buf[2]} == "var")
			return KIND_VAR;
		if (word_len == 2 && {word_buf[0], word_buf[1]} == "if")
			return KIND_IF;
		if (word_len == 5 && {word_buf[0], word_buf[1], word_buf[2], word_buf[3],
				word_buf[4]} == "while")
			return KIND_WHILE;
		if (word_len == 6 && {word_buf[0], word_buf[1], word_buf[2], word_buf[3],
				word_buf[4], word_buf[5]} == "return")
			return KIND_RETURN;
		return KIND_IDENT;
	endfunction

	// scan one accepted byte and queue the tokens it closes or forms
	task automatic lex_byte(input logic [7:0] c);
		result_t     res[2];
		int          n;
		logic        extend;
		token_kind_t op;
		n = 0;
		extend = 1'b0;
		// a pending number or identifier either grows or is emitted
		case (scan)
			MODE_NUM: begin
				if (is_num(c))
					extend = 1'b1;
				else begin
					res[n] = make_token(KIND_INT, 1'b0, 16'd0, 16'd0);
					n++;
				end
			end
			MODE_WORD: begin
				if (is_letter(c) || is_num(c)) begin
					extend = 1'b1;
					if (word_len < KEYWORD_MAX)
						word_buf[word_len] = c;
					if (word_len <= KEYWORD_MAX)
						word_len++;
				end else begin
					res[n] = make_token(word_kind(), 1'b0, 16'd0, 16'd0);
					n++;
				end
			end
			default: ;
		endcase
		// the byte itself
		if (!extend) begin
			scan = MODE_GAP;
			op = op_kind(c);
			if (c == 8'h00) begin
				res[n] = make_token(KIND_EOF, 1'b0, 16'd0, 16'd0);
				n++;
				line_no = 16'd1;
				col_no = 16'd1;
			end else if (op != KIND_EOF) begin
				res[n] = make_token(op, 1'b0, 16'd0, 16'd0);
				n++;
			end else if (is_num(c)) begin
				scan = MODE_NUM;
			end else if (is_letter(c)) begin
				scan = MODE_WORD;
				word_buf[0] = c;
				word_len = 1;
			end else if (!is_space(c)) begin
				res[n] = make_token(KIND_EOF, 1'b1, line_no, col_no);
				n++;
			end
		end
		// position of the next byte, saturating
		if (c != 8'h00) begin
			if (c == 8'h0A) begin
				if (line_no != POS_MAX)
					line_no = line_no + 16'd1;
				col_no = 16'd1;
			end else if (col_no != POS_MAX) begin
				col_no = col_no + 16'd1;
			end
		end
		if (n > 0)
			res[n - 1].last_of_run = 1'b1;
		for (int i = 0; i < n; i++)
			tokens_due.push_back(res[i]);
	endtask

	task automatic put_byte(input logic [7:0] b);
		src_bytes.push_back(b);
		rand_items++;
	endtask

	task automatic put_text(input string s);
		foreach (s[i])
			put_byte(s[i]);
	endtask

	function automatic logic [7:0] word_char(logic cont);
		int r;
		r = $urandom_range(cont ? 62 : 52);
		if (r < 26)
			return 8'("a" + r);
		if (r < 52)
			return 8'("A" + r - 26);
		if (r == 52)
			return "_";
		return 8'("0" + r - 53);
	endfunction

	// bytes that no token can start
	function automatic logic [7:0] odd_byte();
		case ($urandom_range(3))
			0: return 8'($urandom_range(128, 255));
			1: return 8'($urandom_range(1, 8));
			2: return 8'($urandom_range(14, 31));
			default: return odd_chars[$urandom_range(odd_chars.len() - 1)];
		endcase
	endfunction

	// cycle count since reset release
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cyc <= 0;
		else
			cyc <= cyc + 1;
	end

	assign quiet = cyc >= QUIET_FROM && cyc < QUIET_TO;

	// long receiver hold-off so the result queue fills and stalls the input
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			hold_left <= 0;
		else if (cyc == HOLD_AT)
			hold_left <= HOLD_LEN;
		else if (hold_left != 0)
			hold_left <= hold_left - 1;
	end

	// byte driver, predicting on each accepted word
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= 8'd0;
		end else begin
			if (s_tvalid && s_tready)
				lex_byte(s_tdata);
			if (!s_tvalid || s_tready) begin
				if (src_bytes.size() != 0 && (quiet || $urandom_range(99) >= 12)) begin
					s_tvalid <= 1'b1;
					s_tdata <= src_bytes.pop_front();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// token monitor
	always @(posedge clk or negedge arst_n) begin
		result_t got;
		result_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.kind = token_kind_t'(m_tdata[4:0]);
				got.error_line = m_tdata[20:5];
				got.error_col = m_tdata[36:21];
				got.bad_char = m_tuser;
				got.last_of_run = m_tlast;
				if (tokens_due.size() == 0) begin
					failed <= 1'b1;
					$display("%0t: token with nothing due: ", $time,
						"kind %0d bad %0b line %0d col %0d last %0b",
						got.kind, got.bad_char, got.error_line, got.error_col,
						got.last_of_run);
				end else begin
					want = tokens_due.pop_front();
					if (got.kind !== want.kind || got.bad_char !== want.bad_char ||
							got.error_line !== want.error_line ||
							got.error_col !== want.error_col ||
							got.last_of_run !== want.last_of_run) begin
						failed <= 1'b1;
						$display("%0t: token mismatch: ", $time,
							"expected kind %0d bad %0b line %0d col %0d last %0b, ",
							want.kind, want.bad_char, want.error_line,
							want.error_col, want.last_of_run,
							"got kind %0d bad %0b line %0d col %0d last %0b",
							got.kind, got.bad_char, got.error_line, got.error_col,
							got.last_of_run);
					end
				end
			end
			m_tready <= hold_left == 0 && (quiet || $urandom_range(99) >= 12);
		end
	end

	// stimulus and end of run
	initial begin
		int   pick;
		int   len;
		logic timed_out;
		string kw;

		// directed: every operator, closers of each pending kind, odd bytes at both
		// ends of the high range, every whitespace byte, eof after a number and alone
		put_text("let+9;(_Z)-{}*/=");
		put_byte(8'hFF);
		put_byte(8'h80);
		foreach (ws_set[i])
			put_byte(ws_set[i]);
		put_byte("7");
		put_byte(8'h00);
		put_byte(8'h00);

		// random texts: mostly well-formed token runs, some odd bytes and noise
		rand_items = 0;
		while (rand_items < RAND_ITEMS) begin
			pick = $urandom_range(99);
			if (pick < 20) begin
				kw = keywords[$urandom_range(4)];
				if ($urandom_range(9) == 0)
					kw = kw.substr(0, kw.len() - 2);
				put_text(kw);
				if ($urandom_range(7) == 0)
					put_byte(word_char(1'b1));
			end else if (pick < 38) begin
				len = $urandom_range(1, 9);
				put_byte(word_char(1'b0));
				repeat (len - 1)
					put_byte(word_char(1'b1));
			end else if (pick < 52) begin
				repeat ($urandom_range(1, 4))
					put_byte(8'("0" + $urandom_range(9)));
			end else if (pick < 72) begin
				put_byte(op_chars[$urandom_range(9)]);
			end else if (pick < 78) begin
				put_byte(odd_byte());
			end else if (pick < 86) begin
				put_byte(8'($urandom_range(255)));
			end else if (pick < 91) begin
				put_byte(8'h00);
			end else begin
				repeat ($urandom_range(1, 3))
					put_byte(ws_set[$urandom_range(5)]);
			end
			if ($urandom_range(99) < 45)
				put_byte(ws_set[$urandom_range(5)]);
		end
		put_byte(8'h00);

		// odd bytes reported on a later line, then a closing identifier
		put_byte("#");
		put_byte(8'h0A);
		put_byte("$");
		put_text("x");
		put_byte(8'h00);

		// reset
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// drain
		while (cyc < LIMIT && (src_bytes.size() != 0 || s_tvalid || tokens_due.size() != 0))
			@(negedge clk);
		timed_out = cyc >= LIMIT;
		if (!timed_out)
			repeat (16) @(negedge clk);
		if (!timed_out && tokens_due.size() != 0) begin
			failed = 1'b1;
			$display("%0t: %0d tokens never arrived, next kind %0d", $time,
				tokens_due.size(), tokens_due[0].kind);
		end
		if (!timed_out && !failed)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
